/* design/sfd_pkg.sv */
`default_nettype none

package sfd_pkg;

    // Header bytes that open every frame.
    localparam logic [7:0] HDR0 = 8'h56;
    localparam logic [7:0] HDR1 = 8'h52;
    localparam logic [7:0] HDR2 = 8'h54;

    // Reset values of the configuration registers.
    localparam logic       BIG_ENDIAN_RST = 1'b0;
    localparam logic [7:0] MAX_REG_ADDR_RST = 8'h20;
    localparam logic [7:0] CMD_FLOOR_RST = 8'h90;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_BIG_ENDIAN = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_REG_ADDR = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CMD_FLOOR = 2'd2;

    // Output frame kinds.
    localparam logic [1:0] KIND_REG = 2'd0;
    localparam logic [1:0] KIND_CMD = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Width of the packed result on the output stream.
    localparam int unsigned RES_W = 42;
    localparam int unsigned M_TDATA_W = 48;

    // Position of the receiver inside a frame.
    typedef enum logic [3:0] {
        POS_HUNT  = 4'd0,
        POS_HDR1  = 4'd1,
        POS_HDR2  = 4'd2,
        POS_CODE  = 4'd3,
        POS_D0    = 4'd4,
        POS_D1    = 4'd5,
        POS_D2    = 4'd6,
        POS_D3    = 4'd7,
        POS_CSUM  = 4'd8
    } pos_t;

    // Configuration as seen by the frame parser.
    typedef struct packed {
        logic       big_endian;
        logic [7:0] max_register_address;
        logic [7:0] command_floor;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic [31:0] data_word;
        logic [7:0]  frame_code;
        logic [1:0]  frame_kind;
    } result_t;

endpackage

`default_nettype wire

/* design/serial_frame_deframer_checksum.sv */
// m_tvalid rises after a checksum byte is transferred: the byte is held in the input register
// and, once the result register has room, is classified into the result register.
// Throughput: one byte per cycle while m_tready stays high; a waiting result stalls input.
// One frame of nine bytes gives at most one result.
// Reset (rst_n low, asynchronous): both stages empty, receiver hunting for a header,
// configuration back to little endian, register limit 0x20 and command floor 0x90.
`default_nettype none

module serial_frame_deframer_checksum (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Input stream, tdata: rx_byte[7:0].
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,
    // Output stream, tdata: frame_kind[1:0], frame_code[9:2], data_word[41:10],
    // zero fill[47:42].
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [sfd_pkg::M_TDATA_W-1:0]            m_tdata,
    // Configuration write port.
    input  wire logic                                cfg_we,
    input  wire logic [sfd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [7:0]                          cfg_wdata
);
    import sfd_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       s_accept;
    logic       process;
    logic       out_free;
    logic       res_valid;
    result_t    res;
    cfg_t       cfg_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.big_endian           <= BIG_ENDIAN_RST;
            cfg_reg.max_register_address <= MAX_REG_ADDR_RST;
            cfg_reg.command_floor        <= CMD_FLOOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_BIG_ENDIAN:   cfg_reg.big_endian           <= cfg_wdata[0];
                CFG_MAX_REG_ADDR: cfg_reg.max_register_address <= cfg_wdata;
                CFG_CMD_FLOOR:    cfg_reg.command_floor        <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // Input register: a held byte moves on once the result register has room.
    always_comb
    begin
        process  = in_valid_reg && out_free;
        s_tready = !in_valid_reg || out_free;
        s_accept = s_tvalid && s_tready;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (process)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    sfd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (process),
        .rx_byte    (in_byte_reg),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    sfd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

/* design/sfd_parser.sv */
`default_nettype none

module sfd_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            byte_valid,
    input  wire logic [7:0]      rx_byte,
    input  wire sfd_pkg::cfg_t   cfg,
    output logic                 res_valid,
    output sfd_pkg::result_t     res
);
    import sfd_pkg::*;

    pos_t       pos_reg;
    pos_t       pos_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] code_reg;
    logic [7:0] data_bytes [4];
    logic       cap_code;
    logic       cap_data;
    logic [1:0] cap_idx;
    logic       csum_ok;
    logic [31:0] word;

    // Frame position and running sum registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HUNT;
            sum_reg <= 8'd0;
        end
        else if (byte_valid)
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // Capture of the code byte and the four data bytes.
    always_ff @(posedge clk)
    begin
        if (byte_valid && cap_code)
        begin
            code_reg <= rx_byte;
        end
        if (byte_valid && cap_data)
        begin
            data_bytes[cap_idx] <= rx_byte;
        end
    end

    // Next position, sum update and capture strobes.
    always_comb
    begin
        pos_next = POS_HUNT;
        sum_next = sum_reg;
        cap_code = 1'b0;
        cap_data = 1'b0;
        cap_idx  = 2'd0;
        case (pos_reg)
            POS_HDR1:
            begin
                if (rx_byte == HDR1)
                begin
                    pos_next = POS_HDR2;
                end
                else if (rx_byte == HDR0)
                begin
                    pos_next = POS_HDR1;
                end
            end
            POS_HDR2:
            begin
                if (rx_byte == HDR2)
                begin
                    pos_next = POS_CODE;
                    sum_next = 8'd0;
                end
                else if (rx_byte == HDR0)
                begin
                    pos_next = POS_HDR1;
                end
            end
            POS_CODE:
            begin
                cap_code = 1'b1;
                sum_next = sum_reg + rx_byte;
                pos_next = POS_D0;
            end
            POS_D0, POS_D1, POS_D2, POS_D3:
            begin
                cap_data = 1'b1;
                cap_idx  = pos_reg[1:0];
                sum_next = sum_reg + rx_byte;
                pos_next = pos_t'(pos_reg + 4'd1);
            end
            POS_CSUM:
            begin
                sum_next = 8'd0;
                pos_next = POS_HUNT;
            end
            default:
            begin
                // Hunting: a first header byte starts a new frame.
                if (rx_byte == HDR0)
                begin
                    pos_next = POS_HDR1;
                end
            end
        endcase
    end

    // Checksum test, word assembly and classification on the checksum byte.
    always_comb
    begin
        csum_ok = (~sum_reg) == rx_byte;
        if (cfg.big_endian)
        begin
            word = {data_bytes[0], data_bytes[1], data_bytes[2], data_bytes[3]};
        end
        else
        begin
            word = {data_bytes[3], data_bytes[2], data_bytes[1], data_bytes[0]};
        end
        res.data_word  = word;
        res.frame_code = code_reg;
        if (!csum_ok)
        begin
            res.frame_kind = KIND_ERR;
        end
        else if (code_reg <= cfg.max_register_address)
        begin
            res.frame_kind = KIND_REG;
        end
        else if (code_reg >= cfg.command_floor)
        begin
            res.frame_kind = KIND_CMD;
        end
        else
        begin
            res.frame_kind = KIND_UNUSED;
        end
        res_valid = byte_valid && (pos_reg == POS_CSUM);
    end

endmodule

`default_nettype wire

/* design/sfd_out_stage.sv */
`default_nettype none

module sfd_out_stage (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               res_valid,
    input  wire sfd_pkg::result_t                   res,
    output logic                                    out_free,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [sfd_pkg::M_TDATA_W-1:0]           m_tdata
);
    import sfd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // The register can take a new result when empty or being drained.
    always_comb
    begin
        out_free = !valid_reg || m_tready;
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RES_W){1'b0}}, res_reg};

endmodule

`default_nettype wire
